// ===== rtl/core/ttc_pkg.sv =====
// Shared constants, types and the control store of the text terminal console.
package ttc_pkg;

	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = COLUMNS * ROWS;
	localparam int ADDR_W  = $clog2(CELLS);
	localparam int ROW_W   = $clog2(ROWS + 1);
	localparam int COL_W   = $clog2(COLUMNS);
	localparam int PC_W    = 5;

	localparam logic [1:0] CMD_PUT    = 2'd0;
	localparam logic [1:0] CMD_REMOVE = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;
	localparam logic [1:0] CMD_READ   = 2'd3;

	localparam logic [7:0]  NEWLINE_CODE = 8'h0A;
	localparam logic [7:0]  SPACE_CODE   = 8'h20;
	localparam logic [7:0]  RESET_COLOR  = 8'h07;
	localparam logic [15:0] RESET_CELL   = {RESET_COLOR, SPACE_CODE};

	// Microprogram step addresses
	localparam logic [PC_W-1:0] PC_INIT      = PC_W'(0);
	localparam logic [PC_W-1:0] PC_IDLE      = PC_W'(1);
	localparam logic [PC_W-1:0] PC_PUT       = PC_W'(2);
	localparam logic [PC_W-1:0] PC_PUT_CHK   = PC_W'(3);
	localparam logic [PC_W-1:0] PC_SC_PRIME  = PC_W'(4);
	localparam logic [PC_W-1:0] PC_SC_COPY   = PC_W'(5);
	localparam logic [PC_W-1:0] PC_SC_LAST   = PC_W'(6);
	localparam logic [PC_W-1:0] PC_SC_BLANK  = PC_W'(7);
	localparam logic [PC_W-1:0] PC_SC_END    = PC_W'(8);
	localparam logic [PC_W-1:0] PC_REM       = PC_W'(9);
	localparam logic [PC_W-1:0] PC_REM_BACK  = PC_W'(10);
	localparam logic [PC_W-1:0] PC_REM_BLANK = PC_W'(11);
	localparam logic [PC_W-1:0] PC_CLR       = PC_W'(12);
	localparam logic [PC_W-1:0] PC_CLR_FILL  = PC_W'(13);
	localparam logic [PC_W-1:0] PC_RD        = PC_W'(14);
	localparam logic [PC_W-1:0] PC_RD_LATCH  = PC_W'(15);
	localparam logic [PC_W-1:0] PC_RESULT    = PC_W'(16);

	typedef enum logic [1:0] {WE_OFF, WE_ON, WE_PUT} we_t;
	typedef enum logic [1:0] {SRC_CHAR, SRC_BLANK, SRC_INIT, SRC_RDATA} wsrc_t;
	typedef enum logic [1:0] {WA_ADDR, WA_BEHIND, WA_CURSOR} wa_t;
	typedef enum logic {RA_AHEAD, RA_CELL} ra_t;
	typedef enum logic [1:0] {ADDR_KEEP, ADDR_ZERO, ADDR_INC} addr_op_t;
	typedef enum logic [2:0] {CUR_KEEP, CUR_HOME, CUR_ADV, CUR_BACK, CUR_LAST} cur_op_t;
	typedef enum logic {LIM_ALL, LIM_COPY} lim_t;
	typedef enum logic [2:0] {
		COND_NEXT, COND_JUMP, COND_LOOP, COND_DISPATCH,
		COND_NOT_OVER, COND_ORIGIN, COND_OUT
	} cond_t;

	typedef struct packed {
		we_t              we;
		wsrc_t            wsrc;
		wa_t              wa;
		ra_t              ra;
		addr_op_t         addr_op;
		cur_op_t          cur_op;
		lim_t             lim;
		logic             cell_ld;
		logic             out_ld;
		cond_t            cond;
		logic [PC_W-1:0]  next;
	} ctl_t;

	typedef struct packed {
		logic lim_hit;
		logic row_over;
		logic at_origin;
		logic out_free;
	} stat_t;

	localparam ctl_t CTL_NOP = '{
		we: WE_OFF, wsrc: SRC_BLANK, wa: WA_ADDR, ra: RA_AHEAD,
		addr_op: ADDR_KEEP, cur_op: CUR_KEEP, lim: LIM_ALL,
		cell_ld: 1'b0, out_ld: 1'b0, cond: COND_NEXT, next: PC_IDLE
	};

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [ADDR_W-1:0] row,
			input logic [ADDR_W-1:0] col);
		return ADDR_W'(row * COLUMNS + col);
	endfunction

	// Control store: one word per step
	function automatic ctl_t ucode(input logic [PC_W-1:0] pc);
		ctl_t c;
		c = CTL_NOP;
		unique case (pc)
			PC_INIT: begin
				c.we = WE_ON; c.wsrc = SRC_INIT; c.wa = WA_ADDR;
				c.addr_op = ADDR_INC; c.lim = LIM_ALL;
				c.cond = COND_LOOP; c.next = PC_IDLE;
			end
			PC_IDLE: begin
				c.addr_op = ADDR_ZERO; c.cond = COND_DISPATCH;
			end
			PC_PUT: begin
				c.we = WE_PUT; c.wsrc = SRC_CHAR; c.wa = WA_CURSOR;
				c.cur_op = CUR_ADV;
			end
			PC_PUT_CHK: begin
				c.addr_op = ADDR_ZERO; c.cond = COND_NOT_OVER; c.next = PC_RESULT;
			end
			PC_SC_PRIME: begin
				c.ra = RA_AHEAD; c.addr_op = ADDR_INC;
			end
			PC_SC_COPY: begin
				c.we = WE_ON; c.wsrc = SRC_RDATA; c.wa = WA_BEHIND; c.ra = RA_AHEAD;
				c.addr_op = ADDR_INC; c.lim = LIM_COPY;
				c.cond = COND_LOOP; c.next = PC_SC_LAST;
			end
			PC_SC_LAST: begin
				c.we = WE_ON; c.wsrc = SRC_RDATA; c.wa = WA_BEHIND;
			end
			PC_SC_BLANK: begin
				c.we = WE_ON; c.wsrc = SRC_BLANK; c.wa = WA_ADDR;
				c.addr_op = ADDR_INC; c.lim = LIM_ALL;
				c.cond = COND_LOOP; c.next = PC_SC_END;
			end
			PC_SC_END: begin
				c.cur_op = CUR_LAST; c.cond = COND_JUMP; c.next = PC_RESULT;
			end
			PC_REM: begin
				c.cond = COND_ORIGIN; c.next = PC_RESULT;
			end
			PC_REM_BACK: begin
				c.cur_op = CUR_BACK;
			end
			PC_REM_BLANK: begin
				c.we = WE_ON; c.wsrc = SRC_BLANK; c.wa = WA_CURSOR;
				c.cond = COND_JUMP; c.next = PC_RESULT;
			end
			PC_CLR: begin
				c.cur_op = CUR_HOME; c.addr_op = ADDR_ZERO;
			end
			PC_CLR_FILL: begin
				c.we = WE_ON; c.wsrc = SRC_BLANK; c.wa = WA_ADDR;
				c.addr_op = ADDR_INC; c.lim = LIM_ALL;
				c.cond = COND_LOOP; c.next = PC_RESULT;
			end
			PC_RD: begin
				c.ra = RA_CELL;
			end
			PC_RD_LATCH: begin
				c.cell_ld = 1'b1;
			end
			PC_RESULT: begin
				c.out_ld = 1'b1; c.cond = COND_OUT; c.next = PC_IDLE;
			end
			default: begin
				c.cond = COND_JUMP; c.next = PC_IDLE;
			end
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/core/ttc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ttc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/ttc_seq.sv =====
// Microcode sequencer: step counter, control store lookup and jump logic.
module ttc_seq (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [1:0]                command,
	input  ttc_pkg::stat_t            stat,
	output ttc_pkg::ctl_t             ctl,
	output logic                      in_ready
);

	logic [ttc_pkg::PC_W-1:0] pc_q;
	logic [ttc_pkg::PC_W-1:0] pc_d;
	logic [ttc_pkg::PC_W-1:0] entry;
	logic [ttc_pkg::PC_W-1:0] pc_inc;

	assign ctl      = ttc_pkg::ucode(pc_q);
	assign in_ready = (ctl.cond == ttc_pkg::COND_DISPATCH);
	assign pc_inc   = pc_q + 1'b1;

	always_comb begin
		unique case (command)
			ttc_pkg::CMD_PUT:    entry = ttc_pkg::PC_PUT;
			ttc_pkg::CMD_REMOVE: entry = ttc_pkg::PC_REM;
			ttc_pkg::CMD_CLEAR:  entry = ttc_pkg::PC_CLR;
			ttc_pkg::CMD_READ:   entry = ttc_pkg::PC_RD;
			default:             entry = ttc_pkg::PC_IDLE;
		endcase
	end

	always_comb begin
		unique case (ctl.cond)
			ttc_pkg::COND_NEXT:     pc_d = pc_inc;
			ttc_pkg::COND_JUMP:     pc_d = ctl.next;
			ttc_pkg::COND_LOOP:     pc_d = stat.lim_hit ? ctl.next : pc_q;
			ttc_pkg::COND_DISPATCH: pc_d = in_valid ? entry : pc_q;
			ttc_pkg::COND_NOT_OVER: pc_d = stat.row_over ? pc_inc : ctl.next;
			ttc_pkg::COND_ORIGIN:   pc_d = stat.at_origin ? ctl.next : pc_inc;
			ttc_pkg::COND_OUT:      pc_d = stat.out_free ? ctl.next : pc_q;
			default:                pc_d = ttc_pkg::PC_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ttc_pkg::PC_INIT;
		end else begin
			pc_q <= pc_d;
		end
	end

endmodule

// ===== rtl/core/ttc_datapath.sv =====
// Datapath: cursor, sweep address, screen store and result register.
module ttc_datapath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ttc_pkg::ctl_t         ctl,
	input  logic                  in_take,
	input  logic [7:0]            char_code,
	input  logic [4:0]            read_row,
	input  logic [6:0]            read_column,
	input  logic [7:0]            text_color,
	input  logic                  out_ready,
	output ttc_pkg::stat_t        stat,
	output logic                  out_valid,
	output logic [4:0]            cursor_row,
	output logic [6:0]            cursor_column,
	output logic [10:0]           cursor_position,
	output logic [7:0]            cell_char,
	output logic [7:0]            cell_attr
);

	localparam int AW = ttc_pkg::ADDR_W;

	logic [7:0]                 char_q;
	logic [4:0]                 rrow_q;
	logic [6:0]                 rcol_q;
	logic [ttc_pkg::ROW_W-1:0]  row_q;
	logic [ttc_pkg::COL_W-1:0]  col_q;
	logic [AW-1:0]              addr_q;
	logic [15:0]                cell_q;
	logic                       out_valid_q;
	logic [4:0]                 out_row_q;
	logic [6:0]                 out_col_q;
	logic [10:0]                out_pos_q;
	logic [15:0]                out_cell_q;

	logic [AW-1:0] cur_addr;
	logic [AW-1:0] rd_cell_addr;
	logic [AW-1:0] lim;
	logic          in_range;
	logic          newline;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [AW-1:0] ram_raddr;
	logic [15:0]   ram_wdata;
	logic [15:0]   ram_rdata;

	assign cur_addr     = ttc_pkg::cell_addr(AW'(row_q), AW'(col_q));
	assign rd_cell_addr = ttc_pkg::cell_addr(AW'(rrow_q), AW'(rcol_q));
	assign in_range     = (rrow_q < ttc_pkg::ROWS) && (rcol_q < ttc_pkg::COLUMNS);
	assign newline      = (char_q == ttc_pkg::NEWLINE_CODE);
	assign lim          = (ctl.lim == ttc_pkg::LIM_COPY) ?
		AW'(ttc_pkg::CELLS - ttc_pkg::COLUMNS - 1) : AW'(ttc_pkg::CELLS - 1);

	assign stat.lim_hit   = (addr_q == lim);
	assign stat.row_over  = (row_q == ttc_pkg::ROW_W'(ttc_pkg::ROWS));
	assign stat.at_origin = (row_q == '0) && (col_q == '0);
	assign stat.out_free  = !out_valid_q || out_ready;

	assign ram_we = (ctl.we == ttc_pkg::WE_ON) || ((ctl.we == ttc_pkg::WE_PUT) && !newline);

	always_comb begin
		case (ctl.wsrc)
			ttc_pkg::SRC_CHAR:  ram_wdata = {text_color, char_q};
			ttc_pkg::SRC_BLANK: ram_wdata = {text_color, ttc_pkg::SPACE_CODE};
			ttc_pkg::SRC_INIT:  ram_wdata = ttc_pkg::RESET_CELL;
			default:            ram_wdata = ram_rdata;
		endcase
	end

	always_comb begin
		case (ctl.wa)
			ttc_pkg::WA_BEHIND: ram_waddr = addr_q - 1'b1;
			ttc_pkg::WA_CURSOR: ram_waddr = cur_addr;
			default:            ram_waddr = addr_q;
		endcase
	end

	// Only an in-range read address reaches the store
	assign ram_raddr = (ctl.ra == ttc_pkg::RA_CELL) ? (in_range ? rd_cell_addr : addr_q) :
		AW'(addr_q + AW'(ttc_pkg::COLUMNS));

	ttc_ram #(
		.WIDTH(16),
		.DEPTH(ttc_pkg::CELLS)
	) u_screen (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (in_take) begin
			char_q <= char_code;
			rrow_q <= read_row;
			rcol_q <= read_column;
		end
		if (in_take) begin
			cell_q <= '0;
		end else if (ctl.cell_ld) begin
			cell_q <= in_range ? ram_rdata : 16'h0000;
		end
		if (ctl.out_ld && stat.out_free) begin
			out_row_q  <= 5'(row_q);
			out_col_q  <= 7'(col_q);
			out_pos_q  <= 11'(cur_addr);
			out_cell_q <= cell_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q       <= '0;
			col_q       <= '0;
			addr_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (ctl.addr_op)
				ttc_pkg::ADDR_ZERO: addr_q <= '0;
				ttc_pkg::ADDR_INC:  addr_q <= addr_q + 1'b1;
				default:            addr_q <= addr_q;
			endcase
			case (ctl.cur_op)
				ttc_pkg::CUR_HOME: begin
					row_q <= '0;
					col_q <= '0;
				end
				ttc_pkg::CUR_ADV: begin
					if (newline || (col_q == ttc_pkg::COL_W'(ttc_pkg::COLUMNS - 1))) begin
						col_q <= '0;
						row_q <= row_q + 1'b1;
					end else begin
						col_q <= col_q + 1'b1;
					end
				end
				ttc_pkg::CUR_BACK: begin
					if (col_q != '0) begin
						col_q <= col_q - 1'b1;
					end else begin
						col_q <= ttc_pkg::COL_W'(ttc_pkg::COLUMNS - 1);
						row_q <= row_q - 1'b1;
					end
				end
				ttc_pkg::CUR_LAST: row_q <= ttc_pkg::ROW_W'(ttc_pkg::ROWS - 1);
				default: begin
					row_q <= row_q;
					col_q <= col_q;
				end
			endcase
			if (ctl.out_ld && stat.out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign cursor_row      = out_row_q;
	assign cursor_column   = out_col_q;
	assign cursor_position = out_pos_q;
	assign cell_char       = out_cell_q[7:0];
	assign cell_attr       = out_cell_q[15:8];

endmodule

// ===== rtl/core/text_terminal_console_unit.sv =====
// Top level of the text terminal console: stream ports, register port, core.
//
// A command enters on the s_ channel: put a character, remove a character,
// clear the screen or read one cell of the 80x25 screen store. Each command
// gives exactly one result on the m_ channel: cursor row, column and linear
// position after the command, plus the character and attribute of the cell
// for a read (zero otherwise). The attribute used for written characters
// and blanks is the text_color register at byte address 0 of the APB port.
// One command is worked at a time by a microcoded sequencer; s_tready is
// high only while it waits for a command. A put that runs off the last
// row scrolls the screen: each cell below the first row is read and
// written one row up, and the last row is blanked. A clear fills all
// 2000 cells, one per cycle. After reset the store is filled with light
// grey spaces; no command is taken during this fill, but register writes
// are taken throughout. The result waits in an output register; while
// the receiver stalls, the next command is still taken and worked, and
// held at its last step.
module text_terminal_console_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,    // char_code[7:0], read_row[12:8], read_column[19:13]
	input  logic [1:0]  s_tuser,    // command[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	// cursor_row[4:0], cursor_column[11:5], cursor_position[22:12],
	// cell_char[30:23], cell_attr[38:31]
	output logic [39:0] m_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	ttc_pkg::ctl_t  ctl;
	ttc_pkg::stat_t stat;
	logic [7:0]     color_q;
	logic           in_take;
	logic [4:0]     cursor_row;
	logic [6:0]     cursor_column;
	logic [10:0]    cursor_position;
	logic [7:0]     cell_char;
	logic [7:0]     cell_attr;

	assign pready  = 1'b1;
	assign prdata  = paddr[2] ? 32'd0 : {24'd0, color_q};
	assign in_take = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q <= ttc_pkg::RESET_COLOR;
		end else if (psel && penable && pwrite && pready && !paddr[2]) begin
			color_q <= pwdata[7:0];
		end
	end

	ttc_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.command  (s_tuser),
		.stat     (stat),
		.ctl      (ctl),
		.in_ready (s_tready)
	);

	ttc_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (ctl),
		.in_take         (in_take),
		.char_code       (s_tdata[7:0]),
		.read_row        (s_tdata[12:8]),
		.read_column     (s_tdata[19:13]),
		.text_color      (color_q),
		.out_ready       (m_tready),
		.stat            (stat),
		.out_valid       (m_tvalid),
		.cursor_row      (cursor_row),
		.cursor_column   (cursor_column),
		.cursor_position (cursor_position),
		.cell_char       (cell_char),
		.cell_attr       (cell_attr)
	);

	assign m_tdata = {1'b0, cell_attr, cell_char, cursor_position, cursor_column, cursor_row};

endmodule

// ===== rtl/core/ttc_checker.sv =====
// Port-level checks for the text terminal console, bound to the top level.
module ttc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [23:0] s_tdata,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic        psel,
	input logic        penable,
	input logic        pwrite,
	input logic [2:0]  paddr,
	input logic [31:0] pwdata,
	input logic [31:0] prdata,
	input logic        pready
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[4:0] < ttc_pkg::ROWS) && (m_tdata[11:5] < ttc_pkg::COLUMNS))
		else $error("cursor outside the screen");

	a_cursor_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (32'(m_tdata[22:12]) ==
			32'(m_tdata[4:0]) * ttc_pkg::COLUMNS + 32'(m_tdata[11:5])))
		else $error("cursor position does not match row and column");

	a_color_readback: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && pready && !paddr[2]) ##1 (psel && !pwrite && !paddr[2])
		|-> prdata[7:0] == $past(pwdata[7:0]))
		else $error("colour register read back wrong");

endmodule

bind text_terminal_console_unit ttc_checker u_chk (.*);
